@@ rtl/core/fraction_arithmetic_reduce_core_assert.svh @@
// assertion helpers shared by the core modules
`ifndef FRACTION_ARITHMETIC_REDUCE_CORE_ASSERT_SVH
`define FRACTION_ARITHMETIC_REDUCE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FAC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fac assertion failed");

// next-cycle implication, checked outside reset
`define FAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fac assertion failed");

`endif

@@ rtl/core/fac_pkg.sv @@
package fac_pkg;

    // output and operation code field widths
    localparam int NUM_W  = 33;
    localparam int DEN_W  = 32;
    localparam int KIND_W = 2;

    typedef logic [KIND_W-1:0] t_kind;

    // operation codes
    localparam t_kind KIND_ADD = 2'd0;
    localparam t_kind KIND_SUB = 2'd1;
    localparam t_kind KIND_MUL = 2'd2;
    localparam t_kind KIND_DIV = 2'd3;

    // back end sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PG,
        ST_PG_W,
        ST_LQ,
        ST_LQ_W,
        ST_LMUL,
        ST_T1,
        ST_T1_W,
        ST_T1M,
        ST_T2,
        ST_T2_W,
        ST_T2M,
        ST_SUM,
        ST_MD1,
        ST_MD2,
        ST_EU,
        ST_EU_W,
        ST_RN,
        ST_RN_W,
        ST_RD,
        ST_RD_W,
        ST_OUT
    } t_back_state;

endpackage

@@ rtl/core/fac_div.sv @@
module fac_div #(
    parameter int MW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_dividend,
    input  logic [MW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [MW-1:0] o_quot,
    output logic [MW-1:0] o_rem
);

    localparam int CW = $clog2(MW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [MW-1:0] r_quo;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_dvs;
    logic [MW:0]   w_shift;
    logic [MW:0]   w_diff;
    logic          w_ge;

    // one restoring step: shift in the next dividend bit and trial subtract
    always_comb begin
        w_shift = {r_rem, r_quo[MW-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = !w_diff[MW];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[MW-1:0] : w_shift[MW-1:0];
            r_quo <= {r_quo[MW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ rtl/core/fac_back.sv @@
`include "fraction_arithmetic_reduce_core_assert.svh"

module fac_back #(
    parameter int W  = 16,
    parameter int DW = 4 * W + 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  logic [DW-1:0]              i_q_data,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [fac_pkg::NUM_W-1:0]  o_res_num,
    output logic [fac_pkg::DEN_W-1:0]  o_res_den,
    output logic                       o_bad_input
);

    localparam int MW = 2 * W;
    localparam int XW = MW + fac_pkg::NUM_W;

    fac_pkg::t_back_state r_state;
    fac_pkg::t_back_state n_state;

    // queue word fields
    logic          w_err;
    fac_pkg::t_kind w_kind;
    logic [W-1:0]  w_na;
    logic [W-1:0]  w_da;
    logic [W-1:0]  w_nb;
    logic [W-1:0]  w_db;
    logic [W-1:0]  w_na_m;
    logic [W-1:0]  w_da_m;
    logic [W-1:0]  w_nb_m;
    logic [W-1:0]  w_db_m;

    // operand registers, sign and magnitude
    fac_pkg::t_kind r_kind;
    logic          r_na_n, r_da_n, r_nb_n, r_db_n;
    logic [W-1:0]  r_na_m, r_da_m, r_nb_m, r_db_m;

    // working registers
    logic [MW-1:0] r_xm, r_ym;
    logic          r_xn, r_yn;
    logic [W-1:0]  r_q;
    logic [MW-1:0] r_l;
    logic [MW-1:0] r_t1m, r_t2m;
    logic          r_t1n, r_t2n;
    logic [MW-1:0] r_nm, r_dm;
    logic          r_nn, r_dn;
    logic [fac_pkg::NUM_W-1:0] r_rn;
    logic [fac_pkg::DEN_W-1:0] r_rd;
    logic          r_bad;

    // output register
    logic          r_ovalid;
    logic [fac_pkg::NUM_W-1:0] r_onum;
    logic [fac_pkg::DEN_W-1:0] r_oden;
    logic          r_obad;
    logic          w_load;

    // shared units
    logic          w_div_start;
    logic [MW-1:0] w_div_a, w_div_b;
    logic          w_div_busy, w_div_done;
    logic [MW-1:0] w_quot, w_rem;
    logic [W-1:0]  w_mul_a, w_mul_b;
    logic [MW-1:0] w_prod;
    logic          w_md_sel_n1, w_md_sel_n2;

    // sum and signed quotient helpers
    logic [MW-1:0] w_sum_m;
    logic          w_sum_n;
    logic          w_q_neg;
    logic [XW-1:0] w_qx;
    logic [XW-1:0] w_qs;

    // unpack and take magnitudes
    always_comb begin
        w_err  = i_q_data[DW-1];
        w_kind = i_q_data[DW-2 -: fac_pkg::KIND_W];
        w_na   = i_q_data[4*W-1 -: W];
        w_da   = i_q_data[3*W-1 -: W];
        w_nb   = i_q_data[2*W-1 -: W];
        w_db   = i_q_data[W-1:0];
        w_na_m = w_na[W-1] ? (~w_na + W'(1)) : w_na;
        w_da_m = w_da[W-1] ? (~w_da + W'(1)) : w_da;
        w_nb_m = w_nb[W-1] ? (~w_nb + W'(1)) : w_nb;
        w_db_m = w_db[W-1] ? (~w_db + W'(1)) : w_db;
    end

    fac_div #(.MW(MW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // single multiplier, product always registered
    assign w_prod = MW'(w_mul_a) * MW'(w_mul_b);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fac_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (w_err) begin
                        n_state = fac_pkg::ST_OUT;
                    end else if (w_kind inside {fac_pkg::KIND_ADD, fac_pkg::KIND_SUB}) begin
                        n_state = fac_pkg::ST_PG;
                    end else begin
                        n_state = fac_pkg::ST_MD1;
                    end
                end
            end
            fac_pkg::ST_PG:   n_state = (r_ym == '0) ? fac_pkg::ST_LQ : fac_pkg::ST_PG_W;
            fac_pkg::ST_PG_W: if (w_div_done) n_state = fac_pkg::ST_PG;
            fac_pkg::ST_LQ:   n_state = fac_pkg::ST_LQ_W;
            fac_pkg::ST_LQ_W: if (w_div_done) n_state = fac_pkg::ST_LMUL;
            fac_pkg::ST_LMUL: n_state = fac_pkg::ST_T1;
            fac_pkg::ST_T1:   n_state = fac_pkg::ST_T1_W;
            fac_pkg::ST_T1_W: if (w_div_done) n_state = fac_pkg::ST_T1M;
            fac_pkg::ST_T1M:  n_state = fac_pkg::ST_T2;
            fac_pkg::ST_T2:   n_state = fac_pkg::ST_T2_W;
            fac_pkg::ST_T2_W: if (w_div_done) n_state = fac_pkg::ST_T2M;
            fac_pkg::ST_T2M:  n_state = fac_pkg::ST_SUM;
            fac_pkg::ST_SUM:  n_state = fac_pkg::ST_EU;
            fac_pkg::ST_MD1:  n_state = fac_pkg::ST_MD2;
            fac_pkg::ST_MD2:  n_state = fac_pkg::ST_EU;
            fac_pkg::ST_EU:   n_state = (r_ym == '0) ? fac_pkg::ST_RN : fac_pkg::ST_EU_W;
            fac_pkg::ST_EU_W: if (w_div_done) n_state = fac_pkg::ST_EU;
            fac_pkg::ST_RN:   n_state = fac_pkg::ST_RN_W;
            fac_pkg::ST_RN_W: if (w_div_done) n_state = fac_pkg::ST_RD;
            fac_pkg::ST_RD:   n_state = fac_pkg::ST_RD_W;
            fac_pkg::ST_RD_W: if (w_div_done) n_state = fac_pkg::ST_OUT;
            fac_pkg::ST_OUT:  if (!r_ovalid || !i_out_stall) n_state = fac_pkg::ST_IDLE;
            default:          n_state = fac_pkg::ST_IDLE;
        endcase
    end

    // unit controls and operand selection
    always_comb begin
        w_div_start = 1'b0;
        w_div_a     = r_xm;
        w_div_b     = r_ym;
        w_mul_a     = r_na_m;
        w_mul_b     = r_db_m;
        o_pop       = 1'b0;
        case (r_state)
            fac_pkg::ST_IDLE: o_pop = i_q_valid;
            fac_pkg::ST_PG:   w_div_start = (r_ym != '0);
            fac_pkg::ST_LQ: begin
                w_div_start = 1'b1;
                w_div_a     = MW'(r_da_m);
                w_div_b     = r_xm;
            end
            fac_pkg::ST_LMUL: begin
                w_mul_a = r_q;
                w_mul_b = r_db_m;
            end
            fac_pkg::ST_T1: begin
                w_div_start = 1'b1;
                w_div_a     = r_l;
                w_div_b     = MW'(r_da_m);
            end
            fac_pkg::ST_T1M: begin
                w_mul_a = r_na_m;
                w_mul_b = r_q;
            end
            fac_pkg::ST_T2: begin
                w_div_start = 1'b1;
                w_div_a     = r_l;
                w_div_b     = MW'(r_db_m);
            end
            fac_pkg::ST_T2M: begin
                w_mul_a = r_nb_m;
                w_mul_b = r_q;
            end
            fac_pkg::ST_MD1: begin
                w_mul_a = r_na_m;
                w_mul_b = (r_kind == fac_pkg::KIND_MUL) ? r_nb_m : r_db_m;
            end
            fac_pkg::ST_MD2: begin
                w_mul_a = r_da_m;
                w_mul_b = (r_kind == fac_pkg::KIND_MUL) ? r_db_m : r_nb_m;
            end
            fac_pkg::ST_EU:   w_div_start = (r_ym != '0);
            fac_pkg::ST_RN: begin
                w_div_start = 1'b1;
                w_div_a     = r_nm;
                w_div_b     = r_xm;
            end
            fac_pkg::ST_RD: begin
                w_div_start = 1'b1;
                w_div_a     = r_dm;
                w_div_b     = r_xm;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    // signs of the cross products
    assign w_md_sel_n1 = (r_kind == fac_pkg::KIND_MUL) ? r_nb_n : r_db_n;
    assign w_md_sel_n2 = (r_kind == fac_pkg::KIND_MUL) ? r_db_n : r_nb_n;

    // signed sum of the two scaled numerators
    always_comb begin
        if (r_t1n == r_t2n) begin
            w_sum_m = r_t1m + r_t2m;
            w_sum_n = r_t1n;
        end else if (r_t1m >= r_t2m) begin
            w_sum_m = r_t1m - r_t2m;
            w_sum_n = r_t1n;
        end else begin
            w_sum_m = r_t2m - r_t1m;
            w_sum_n = r_t2n;
        end
    end

    // truncating quotient back to two's complement
    always_comb begin
        w_q_neg = (r_state == fac_pkg::ST_RN_W) ? (r_nn ^ r_xn) : (r_dn ^ r_xn);
        w_qx    = XW'(w_quot);
        w_qs    = w_q_neg ? (~w_qx + XW'(1)) : w_qx;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            fac_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    r_kind <= w_kind;
                    r_na_n <= w_na[W-1];
                    r_da_n <= w_da[W-1];
                    r_nb_n <= w_nb[W-1];
                    r_db_n <= w_db[W-1];
                    r_na_m <= w_na_m;
                    r_da_m <= w_da_m;
                    r_nb_m <= w_nb_m;
                    r_db_m <= w_db_m;
                    r_xm   <= MW'(w_da_m);
                    r_ym   <= MW'(w_db_m);
                    r_rn   <= '0;
                    r_rd   <= '0;
                    r_bad  <= w_err;
                end
            end
            fac_pkg::ST_PG_W: begin
                if (w_div_done) begin
                    r_xm <= r_ym;
                    r_ym <= w_rem;
                end
            end
            fac_pkg::ST_LQ_W, fac_pkg::ST_T1_W, fac_pkg::ST_T2_W: begin
                if (w_div_done) begin
                    r_q <= w_quot[W-1:0];
                end
            end
            fac_pkg::ST_LMUL: r_l <= w_prod;
            fac_pkg::ST_T1M: begin
                r_t1m <= w_prod;
                r_t1n <= r_na_n ^ r_da_n;
            end
            fac_pkg::ST_T2M: begin
                r_t2m <= w_prod;
                r_t2n <= r_nb_n ^ r_db_n ^ (r_kind == fac_pkg::KIND_SUB);
            end
            fac_pkg::ST_SUM: begin
                r_nm <= w_sum_m;
                r_nn <= w_sum_n && (w_sum_m != '0);
                r_dm <= r_l;
                r_dn <= 1'b0;
                r_xm <= w_sum_m;
                r_xn <= w_sum_n && (w_sum_m != '0);
                r_ym <= r_l;
                r_yn <= 1'b0;
            end
            fac_pkg::ST_MD1: begin
                r_nm <= w_prod;
                r_nn <= (r_na_n ^ w_md_sel_n1) && (w_prod != '0);
            end
            fac_pkg::ST_MD2: begin
                r_dm <= w_prod;
                r_dn <= r_da_n ^ w_md_sel_n2;
                r_xm <= r_nm;
                r_xn <= r_nn;
                r_ym <= w_prod;
                r_yn <= r_da_n ^ w_md_sel_n2;
            end
            fac_pkg::ST_EU_W: begin
                if (w_div_done) begin
                    r_xm <= r_ym;
                    r_xn <= r_yn;
                    r_ym <= w_rem;
                    r_yn <= r_xn && (w_rem != '0);
                end
            end
            fac_pkg::ST_RN_W: begin
                if (w_div_done) begin
                    r_rn <= w_qs[fac_pkg::NUM_W-1:0];
                end
            end
            fac_pkg::ST_RD_W: begin
                if (w_div_done) begin
                    r_rd <= w_qs[fac_pkg::DEN_W-1:0];
                end
            end
            default: begin
                r_bad <= r_bad;
            end
        endcase
    end

    // output register, free again once the word is taken
    assign w_load = (r_state == fac_pkg::ST_OUT) && (!r_ovalid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_onum <= r_rn;
            r_oden <= r_rd;
            r_obad <= r_bad;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_res_num   = r_onum;
    assign o_res_den   = r_oden;
    assign o_bad_input = r_obad;

    // divider is never restarted mid division
    `FAC_ASSERT_NOW(a_div_idle_start, w_div_start, !w_div_busy)
    // an error word carries a zero fraction
    `FAC_ASSERT_NOW(a_bad_zero, o_out_valid && o_bad_input, (o_res_num == '0) && (o_res_den == '0))
    // a stalled result word holds
    `FAC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_res_num) && $stable(o_res_den) && $stable(o_bad_input))

endmodule

@@ rtl/core/fac_queue.sv @@
`include "fraction_arithmetic_reduce_core_assert.svh"

module fac_queue #(
    parameter int DW = 67
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // two entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // no overflow and no underflow
    `FAC_ASSERT_NOW(a_q_no_overflow, i_push, r_cnt != 2'd2)
    `FAC_ASSERT_NOW(a_q_no_underflow, i_pop, r_cnt != 2'd0)
    // fill count never passes the depth
    `FAC_ASSERT_NOW(a_q_cnt_range, 1'b1, r_cnt != 2'd3)

endmodule

@@ rtl/core/fac_front.sv @@
module fac_front #(
    parameter int W  = 16,
    parameter int DW = 4 * W + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fac_pkg::t_kind       i_kind,
    input  logic [W-1:0]         i_num_a,
    input  logic [W-1:0]         i_den_a,
    input  logic [W-1:0]         i_num_b,
    input  logic [W-1:0]         i_den_b,
    output logic                 o_push,
    output logic [DW-1:0]        o_data,
    input  logic                 i_full
);

    logic          r_valid;
    logic          n_valid;
    logic [DW-1:0] r_data;
    logic          w_accept;
    logic          w_err;

    // flag zero denominators and a zero divisor
    assign w_err = (i_den_a == '0) || (i_den_b == '0) ||
                   ((i_kind == fac_pkg::KIND_DIV) && (i_num_b == '0));

    // handshake with the queue
    assign o_in_stall = r_valid && i_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_full;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // classified word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= {w_err, i_kind, i_num_a, i_den_a, i_num_b, i_den_b};
        end
    end

    assign o_data = r_data;

endmodule

@@ rtl/core/fraction_arithmetic_reduce_core.sv @@
// Fraction arithmetic core: takes num_a/den_a and num_b/den_b with an operation
// (add, subtract, multiply, divide) and returns the result reduced by a signed
// Euclid gcd, so the denominator may come out negative. A zero denominator or a
// divide by a zero fraction gives bad_input with a 0/0 result. A front stage
// checks and queues words (two deep), a back sequencer does the work on one
// shared multiplier and one radix-2 divider, one word at a time. A word takes
// (euclid steps + 2) divisions for multiply and divide, plus the plain gcd
// steps and three more divisions for add and subtract.
module fraction_arithmetic_reduce_core #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [fac_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [VALUE_WIDTH-1:0]     i_num_a,
    input  logic signed [VALUE_WIDTH-1:0]     i_den_a,
    input  logic signed [VALUE_WIDTH-1:0]     i_num_b,
    input  logic signed [VALUE_WIDTH-1:0]     i_den_b,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [fac_pkg::NUM_W-1:0]  o_res_num,
    output logic signed [fac_pkg::DEN_W-1:0]  o_res_den,
    output logic                              o_bad_input
);

    localparam int DW = 4 * VALUE_WIDTH + 3;

    logic          w_push;
    logic [DW-1:0] w_push_data;
    logic          w_full;
    logic          w_pop;
    logic          w_q_valid;
    logic [DW-1:0] w_q_data;

    // front: accept and classify
    fac_front #(.W(VALUE_WIDTH), .DW(DW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_num_a    (i_num_a),
        .i_den_a    (i_den_a),
        .i_num_b    (i_num_b),
        .i_den_b    (i_den_b),
        .o_push     (w_push),
        .o_data     (w_push_data),
        .i_full     (w_full)
    );

    // queue between the two halves
    fac_queue #(.DW(DW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    // back: compute and reduce
    fac_back #(.W(VALUE_WIDTH), .DW(DW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_bad_input (o_bad_input)
    );

endmodule

@@ bench/tb_fraction_arithmetic_reduce_core.sv @@
module tb_fraction_arithmetic_reduce_core;

    localparam int VW = 16;

    typedef struct {
        fac_pkg::t_kind        kind;
        logic signed [VW-1:0]  na;
        logic signed [VW-1:0]  da;
        logic signed [VW-1:0]  nb;
        logic signed [VW-1:0]  db;
    } t_fraction_word;

    typedef struct packed {
        logic signed [fac_pkg::NUM_W-1:0] rn;
        logic signed [fac_pkg::DEN_W-1:0] rd;
        logic                             bad;
    } t_reduced;

    typedef struct {
        t_fraction_word w;
        bit             typed;
        t_reduced       res;
    } t_stim_row;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [fac_pkg::KIND_W-1:0]        i_kind = '0;
    logic signed [VW-1:0]              i_num_a = '0;
    logic signed [VW-1:0]              i_den_a = '0;
    logic signed [VW-1:0]              i_num_b = '0;
    logic signed [VW-1:0]              i_den_b = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic signed [fac_pkg::NUM_W-1:0]  o_res_num;
    logic signed [fac_pkg::DEN_W-1:0]  o_res_den;
    logic                              o_bad_input;

    fraction_arithmetic_reduce_core #(.VALUE_WIDTH(VW)) dut (.*);

    always #4 i_clk = ~i_clk;

    t_reduced pending_q[$];
    bit       typed_flag_q[$];
    t_reduced typed_q[$];
    int       mismatches = 0;
    int       words_in = 0;
    int       words_out = 0;
    int       bad_seen = 0;
    bit       idle_en = 1'b1;

    // exact rational reduction with a signed euclid gcd
    function automatic t_reduced reduce_fraction(t_fraction_word w);
        t_reduced o;
        longint na, da, nb, db, n, d, x, y, r, l, ga, gb;
        na = w.na; da = w.da; nb = w.nb; db = w.db;
        o.bad = 1'b0;
        if (da == 0 || db == 0 || (w.kind == fac_pkg::KIND_DIV && nb == 0)) begin
            o.rn = '0;
            o.rd = '0;
            o.bad = 1'b1;
            return o;
        end
        case (w.kind)
            fac_pkg::KIND_ADD, fac_pkg::KIND_SUB: begin
                ga = (da < 0) ? -da : da;
                gb = (db < 0) ? -db : db;
                x = ga; y = gb;
                while (y != 0) begin
                    r = x % y; x = y; y = r;
                end
                l = (ga / x) * gb;
                if (w.kind == fac_pkg::KIND_ADD) n = na * (l / da) + nb * (l / db);
                else n = na * (l / da) - nb * (l / db);
                d = l;
            end
            fac_pkg::KIND_MUL: begin
                n = na * nb;
                d = da * db;
            end
            default: begin
                n = na * db;
                d = da * nb;
            end
        endcase
        x = n; y = d;
        while (y != 0) begin
            r = x % y; x = y; y = r;
        end
        o.rn = fac_pkg::NUM_W'(n / x);
        o.rd = fac_pkg::DEN_W'(d / x);
        return o;
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return VW'($urandom);
        if (sel < 80) return VW'($urandom_range(40) - 20);
        if (sel < 90) return VW'(1 << $urandom_range(VW - 1));
        return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endfunction

    // word acceptance and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            t_fraction_word w;
            w.kind = i_kind; w.na = i_num_a; w.da = i_den_a;
            w.nb = i_num_b; w.db = i_den_b;
            pending_q.push_back(reduce_fraction(w));
            words_in++;
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_reduced e;
            t_reduced t;
            bit has_t;
            words_out++;
            if (o_bad_input) bad_seen++;
            if (pending_q.size() == 0) begin
                $error("unexpected result word");
                mismatches++;
            end else begin
                e = pending_q.pop_front();
                has_t = typed_flag_q.pop_front();
                t = typed_q.pop_front();
                if (has_t && t != e) begin
                    $error("table row res_num %0d res_den %0d bad_input %0d, predictor %0d %0d %0d",
                           t.rn, t.rd, t.bad, e.rn, e.rd, e.bad);
                    mismatches++;
                end
                if (o_res_num !== e.rn) begin
                    $error("res_num expected %0d got %0d", e.rn, o_res_num);
                    mismatches++;
                end
                if (o_res_den !== e.rd) begin
                    $error("res_den expected %0d got %0d", e.rd, o_res_den);
                    mismatches++;
                end
                if (o_bad_input !== e.bad) begin
                    $error("bad_input expected %0d got %0d", e.bad, o_bad_input);
                    mismatches++;
                end
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= idle_en && ($urandom_range(99) < 32);
    end

    task automatic send_word(t_fraction_word w, bit typed, t_reduced res);
        if (idle_en && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 32) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= w.kind;
        i_num_a <= w.na; i_den_a <= w.da;
        i_num_b <= w.nb; i_den_b <= w.db;
        typed_flag_q.push_back(typed);
        typed_q.push_back(res);
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    function automatic t_stim_row row(fac_pkg::t_kind k, int na, int da, int nb, int db,
                                      bit typed = 0, longint rn = 0, longint rd = 0,
                                      bit bad = 0);
        t_stim_row s;
        s.w.kind = k; s.w.na = VW'(na); s.w.da = VW'(da);
        s.w.nb = VW'(nb); s.w.db = VW'(db);
        s.typed = typed;
        s.res.rn = fac_pkg::NUM_W'(rn); s.res.rd = fac_pkg::DEN_W'(rd); s.res.bad = bad;
        return s;
    endfunction

    t_stim_row table_rows[$];

    initial begin
        t_fraction_word w;
        t_reduced none;
        none = '0;
        // directed table
        table_rows.push_back(row(fac_pkg::KIND_ADD, 1, 0, 1, 1, 1, 0, 0, 1));
        table_rows.push_back(row(fac_pkg::KIND_SUB, 1, 1, 1, 0, 1, 0, 0, 1));
        table_rows.push_back(row(fac_pkg::KIND_DIV, 3, 4, 0, 5, 1, 0, 0, 1));
        table_rows.push_back(row(fac_pkg::KIND_MUL, 0, 0, 0, 0, 1, 0, 0, 1));
        table_rows.push_back(row(fac_pkg::KIND_ADD, 0, 1, 0, 1, 1, 0, 1, 0));
        table_rows.push_back(row(fac_pkg::KIND_MUL, 0, 7, 5, 3, 1, 0, 1, 0));
        table_rows.push_back(row(fac_pkg::KIND_ADD, 1, 2, 1, 3));
        table_rows.push_back(row(fac_pkg::KIND_SUB, 1, 2, 1, 3));
        table_rows.push_back(row(fac_pkg::KIND_MUL, 2, 3, 3, 4));
        table_rows.push_back(row(fac_pkg::KIND_DIV, 2, 3, 3, 4));
        table_rows.push_back(row(fac_pkg::KIND_ADD, -1, 2, 1, -3));
        table_rows.push_back(row(fac_pkg::KIND_DIV, 5, -6, -7, 9));
        table_rows.push_back(row(fac_pkg::KIND_MUL, -32768, -32768, -32768, -32768));
        table_rows.push_back(row(fac_pkg::KIND_ADD, 32767, -32768, 32767, 32767));
        table_rows.push_back(row(fac_pkg::KIND_SUB, -32768, 32767, 32767, -32768));
        table_rows.push_back(row(fac_pkg::KIND_DIV, 32767, 32767, -32768, 1));
        table_rows.push_back(row(fac_pkg::KIND_MUL, -1, -1, -1, -1));
        table_rows.push_back(row(fac_pkg::KIND_SUB, 3, 5, 3, 5));
        table_rows.push_back(row(fac_pkg::KIND_ADD, 32767, 32749, 32767, 32719));
        table_rows.push_back(row(fac_pkg::KIND_DIV, -32768, -1, -1, -32768));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[i])
            send_word(table_rows[i].w, table_rows[i].typed, table_rows[i].res);

        // random words, with a stretch free of gaps and stalls and one full drain
        for (int i = 0; i < 350; i++) begin
            idle_en = !(i >= 150 && i < 220);
            if (i == 100) begin
                i_in_valid <= 1'b0;
                while (pending_q.size() != 0) @(posedge i_clk);
            end
            w.kind = fac_pkg::t_kind'($urandom_range(3));
            w.na = pick_value(); w.da = pick_value();
            w.nb = pick_value(); w.db = pick_value();
            send_word(w, 1'b0, none);
        end
        i_in_valid <= 1'b0;
        idle_en = 1'b1;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        $display("covered %0d words in, %0d results out, %0d flagged bad input",
                 words_in, words_out, bad_seen);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ fraction_arithmetic_reduce_core.f @@
+incdir+rtl/core
rtl/core/fac_pkg.sv
rtl/core/fac_div.sv
rtl/core/fac_back.sv
rtl/core/fac_queue.sv
rtl/core/fac_front.sv
rtl/core/fraction_arithmetic_reduce_core.sv
bench/tb_fraction_arithmetic_reduce_core.sv
